FILE: rtl/core/pidds_pkg.sv
// ----------------------------------------------------------------------------
// pidds_pkg
// Shared types and constants for the PID differential steering block.
// ----------------------------------------------------------------------------
package pidds_pkg;

  // Fixed field widths
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned SPEED_W     = 9;
  localparam int unsigned SERVO_W     = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Result limits
  localparam int SPEED_MAX = 255;
  localparam int SERVO_MAX = 100;

  // PID output is held to +-2^ACC_LIMIT_EXP; CLAMP_W holds that range signed
  localparam int unsigned ACC_LIMIT_EXP = 46;
  localparam int unsigned CLAMP_W       = ACC_LIMIT_EXP + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_DRIVE_SCALE  = 3'd3,
    REG_LEFT_BASE    = 3'd4,
    REG_RIGHT_BASE   = 3'd5,
    REG_SERVO_CENTRE = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SCALE
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [GAIN_W-1:0]         drive_scale;
    logic signed [SPEED_W-1:0] left_base;
    logic signed [SPEED_W-1:0] right_base;
    logic [SERVO_W-1:0]        servo_centre;
  } cfg_t;

  // Defaults: Kp 2.6, Ki 0, Kd 0.1, scale 0.1 (Q4.12)
  localparam cfg_t CFG_RESET = '{
    gain_p:       16'd10650,
    gain_i:       16'd0,
    gain_d:       16'd410,
    drive_scale:  16'd410,
    left_base:    9'sd160,
    right_base:   9'sd160,
    servo_centre: 7'd52
  };

  typedef struct packed {
    logic start;  // load multiplicand and multiplier
    logic clear;  // zero the accumulator with start
  } mac_ctrl_t;

endpackage

FILE: rtl/core/pidds_serial_mac.sv
// ----------------------------------------------------------------------------
// pidds_serial_mac
// Shift-add multiply-accumulate, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module pidds_serial_mac
  import pidds_pkg::*;
#(
  parameter int unsigned MC_W  = 48,
  parameter int unsigned ACC_W = 66
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [MC_W-1:0]  mcand_i,
  input  logic [GAIN_W-1:0]       mult_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    idle_o
);

  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [GAIN_W-1:0]       mult_q, mult_d;

  // runs until the remaining multiplier bits are all zero
  assign idle_o = (mult_q == '0);
  assign acc_o  = acc_q;

  always_comb begin
    mcand_d = mcand_q;
    mult_d  = mult_q;
    acc_d   = acc_q;
    if (ctrl_i.start) begin
      mcand_d = ACC_W'(mcand_i);
      mult_d  = mult_i;
      if (ctrl_i.clear) begin
        acc_d = '0;
      end
    end else if (!idle_o) begin
      if (mult_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d = mcand_q <<< 1;
      mult_d  = mult_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= '0;
    end else begin
      mult_q <= mult_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> idle_o)
    else $error("multiply started while a pass is running");

  a_mult_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!idle_o && !ctrl_i.start) |=> (mult_q == ($past(mult_q) >> 1)))
    else $error("multiplier did not advance by one bit");

endmodule

FILE: rtl/core/pidds_shaper.sv
// ----------------------------------------------------------------------------
// pidds_shaper
// Turns the scaled PID output into clamped motor speeds and servo position,
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pidds_shaper
  import pidds_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned ACC_W     = 66
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      launch_i,
  input  logic signed [ACC_W-1:0]   prod_i,
  input  logic signed [CLAMP_W-1:0] pid_i,
  input  cfg_t                      cfg_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SPEED_W-1:0] left_speed_o,
  output logic signed [SPEED_W-1:0] right_speed_o,
  output logic [SERVO_W-1:0]        servo_position_o
);

  localparam int unsigned LR_W  = ACC_W + 1;
  localparam int unsigned LR_SH = 2 * FRAC_BITS;
  localparam int unsigned SV_W  = CLAMP_W + 1;

  logic                     s1_valid_q;
  logic signed [LR_W-1:0]   sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic signed [SV_W-1:0]   sum_s_q, sum_s_d;

  logic signed [LR_W-1:0]   l_quot, r_quot;
  logic signed [SV_W-1:0]   s_quot;
  logic                     l_rnd, r_rnd, s_rnd;

  logic                     out_valid_q;
  logic signed [SPEED_W-1:0] left_q, left_d, right_q, right_d;
  logic [SERVO_W-1:0]       servo_q, servo_d;

  // stage 1: bring bases onto the product scale and centre onto the PID scale
  always_comb begin
    sum_l_d = (LR_W'(cfg_i.left_base) <<< LR_SH) + LR_W'(prod_i);
    sum_r_d = (LR_W'(cfg_i.right_base) <<< LR_SH) - LR_W'(prod_i);
    sum_s_d = (SV_W'($signed({1'b0, cfg_i.servo_centre})) <<< FRAC_BITS) + SV_W'(pid_i);
  end

  // stage 2: truncate toward zero, then clamp
  always_comb begin
    l_rnd  = sum_l_q[LR_W-1] && (sum_l_q[LR_SH-1:0] != '0);
    r_rnd  = sum_r_q[LR_W-1] && (sum_r_q[LR_SH-1:0] != '0);
    s_rnd  = sum_s_q[SV_W-1] && (sum_s_q[FRAC_BITS-1:0] != '0);
    l_quot = (sum_l_q >>> LR_SH) + $signed({{(LR_W-1){1'b0}}, l_rnd});
    r_quot = (sum_r_q >>> LR_SH) + $signed({{(LR_W-1){1'b0}}, r_rnd});
    s_quot = (sum_s_q >>> FRAC_BITS) + $signed({{(SV_W-1){1'b0}}, s_rnd});

    if (l_quot > SPEED_MAX) begin
      left_d = SPEED_W'(SPEED_MAX);
    end else if (l_quot < -SPEED_MAX) begin
      left_d = SPEED_W'(-SPEED_MAX);
    end else begin
      left_d = $signed(l_quot[SPEED_W-1:0]);
    end

    if (r_quot > SPEED_MAX) begin
      right_d = SPEED_W'(SPEED_MAX);
    end else if (r_quot < -SPEED_MAX) begin
      right_d = SPEED_W'(-SPEED_MAX);
    end else begin
      right_d = $signed(r_quot[SPEED_W-1:0]);
    end

    if (s_quot > SERVO_MAX) begin
      servo_d = SERVO_W'(SERVO_MAX);
    end else if (s_quot < 0) begin
      servo_d = '0;
    end else begin
      servo_d = s_quot[SERVO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= launch_i;
      if (s1_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch_i) begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
      sum_s_q <= sum_s_d;
    end
    if (s1_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      servo_q <= servo_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_speed_o     = left_q;
  assign right_speed_o    = right_q;
  assign servo_position_o = servo_q;

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !out_valid_q)
    else $error("result stage overwrote a waiting result");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((servo_q <= SERVO_W'(SERVO_MAX)) && (left_q != -256)
                     && (right_q != -256)))
    else $error("result outside its clamp range");

endmodule

FILE: rtl/core/pid_differential_steering.sv
// ----------------------------------------------------------------------------
// pid_differential_steering
// Discrete PID line follower: one position error in, left/right motor speeds
// and a servo position out, built round a shared bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | request when
//  ---------+-----+------------------------------------------+----------------------
//  in       | in  | position_error_i                         | in_valid_i & !in_stall_o
//  out      | out | left_speed_o right_speed_o servo_position_o | out_valid_o & !out_stall_i
//  cfg      | in  | cfg_idx_i cfg_wdata_i                    | cfg_we_i
//
//  A request passes four times through the shift-add multiplier (Kp*e, Ki*sum,
//  Kd*diff, then drive scale), one gain bit per cycle. A new request is taken
//  once the scaling pass is done; a result may still wait in the output
//  register then, and a stalled result holds the scaling pass of the next one.
//  Reset clears the integral, the previous error and restores the default
//  registers. A stalled output holds its result.
// ----------------------------------------------------------------------------
module pid_differential_steering
  import pidds_pkg::*;
#(
  parameter int unsigned ERROR_BITS = 10,
  parameter int unsigned SUM_BITS   = 24,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ERROR_BITS-1:0] position_error_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SPEED_W-1:0]   left_speed_o,
  output logic signed [SPEED_W-1:0]   right_speed_o,
  output logic [SERVO_W-1:0]          servo_position_o
);

  localparam int unsigned OPND_W = (SUM_BITS > ERROR_BITS + 1) ? SUM_BITS : ERROR_BITS + 1;
  localparam int unsigned MC_W   = (OPND_W > CLAMP_W) ? OPND_W : CLAMP_W;
  localparam int unsigned ACC_W  = MC_W + GAIN_W + 2;

  localparam logic signed [SUM_BITS:0] SUM_MAX = $signed({2'b00, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [SUM_BITS:0] SUM_MIN = $signed({2'b11, {(SUM_BITS-1){1'b0}}});
  localparam logic signed [ACC_W-1:0]  ACC_LIM = ACC_W'(1) <<< ACC_LIMIT_EXP;

  state_e                       state_q, state_d;
  cfg_t                         cfg_q, cfg_d;
  logic signed [SUM_BITS-1:0]   error_sum_q, error_sum_d;
  logic signed [ERROR_BITS-1:0] previous_error_q, previous_error_d;
  logic signed [ERROR_BITS:0]   diff_q, diff_d;
  logic signed [CLAMP_W-1:0]    pid_q, pid_d;
  logic signed [SUM_BITS:0]     sum_ext;

  logic                         accept;
  mac_ctrl_t                    mac_ctrl;
  logic signed [MC_W-1:0]       mac_mcand;
  logic [GAIN_W-1:0]            mac_mult;
  logic signed [ACC_W-1:0]      mac_acc;
  logic                         mac_idle;
  logic                         shp_launch;
  logic                         pid_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // configuration decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_P:       cfg_d.gain_p       = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_I:       cfg_d.gain_i       = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:       cfg_d.gain_d       = cfg_wdata_i[GAIN_W-1:0];
        REG_DRIVE_SCALE:  cfg_d.drive_scale  = cfg_wdata_i[GAIN_W-1:0];
        REG_LEFT_BASE:    cfg_d.left_base    = $signed(cfg_wdata_i[SPEED_W-1:0]);
        REG_RIGHT_BASE:   cfg_d.right_base   = $signed(cfg_wdata_i[SPEED_W-1:0]);
        REG_SERVO_CENTRE: cfg_d.servo_centre = cfg_wdata_i[SERVO_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // integral and derivative, updated on the accepting edge
  always_comb begin
    sum_ext          = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(position_error_i);
    error_sum_d      = error_sum_q;
    previous_error_d = previous_error_q;
    diff_d           = diff_q;
    if (accept) begin
      if (sum_ext > SUM_MAX) begin
        error_sum_d = SUM_MAX[SUM_BITS-1:0];
      end else if (sum_ext < SUM_MIN) begin
        error_sum_d = SUM_MIN[SUM_BITS-1:0];
      end else begin
        error_sum_d = sum_ext[SUM_BITS-1:0];
      end
      previous_error_d = position_error_i;
      diff_d = (ERROR_BITS+1)'(position_error_i) - (ERROR_BITS+1)'(previous_error_q);
    end
  end

  // PID output held to +-2^46 before scaling
  always_comb begin
    if (mac_acc > ACC_LIM) begin
      pid_d = ACC_LIM[CLAMP_W-1:0];
    end else if (mac_acc < -ACC_LIM) begin
      pid_d = CLAMP_W'(-ACC_LIM);
    end else begin
      pid_d = mac_acc[CLAMP_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    mac_ctrl       = '0;
    mac_mcand      = '0;
    mac_mult       = '0;
    shp_launch     = 1'b0;
    pid_load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mac_ctrl  = '{start: 1'b1, clear: 1'b1};
          mac_mcand = MC_W'(position_error_i);
          mac_mult  = cfg_q.gain_p;
          state_d   = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mac_idle) begin
          mac_ctrl  = '{start: 1'b1, clear: 1'b0};
          mac_mcand = MC_W'(error_sum_q);
          mac_mult  = cfg_q.gain_i;
          state_d   = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        if (mac_idle) begin
          mac_ctrl  = '{start: 1'b1, clear: 1'b0};
          mac_mcand = MC_W'(diff_q);
          mac_mult  = cfg_q.gain_d;
          state_d   = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        if (mac_idle) begin
          mac_ctrl  = '{start: 1'b1, clear: 1'b1};
          mac_mcand = MC_W'(pid_d);
          mac_mult  = cfg_q.drive_scale;
          pid_load  = 1'b1;
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // output register must be empty by the time stage 2 writes it
        if (mac_idle && (!out_valid_o || !out_stall_i)) begin
          shp_launch = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cfg_q            <= CFG_RESET;
      error_sum_q      <= '0;
      previous_error_q <= '0;
    end else begin
      state_q          <= state_d;
      cfg_q            <= cfg_d;
      error_sum_q      <= error_sum_d;
      previous_error_q <= previous_error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    if (pid_load) begin
      pid_q <= pid_d;
    end
  end

  pidds_serial_mac #(
    .MC_W  (MC_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .mcand_i (mac_mcand),
    .mult_i  (mac_mult),
    .acc_o   (mac_acc),
    .idle_o  (mac_idle)
  );

  pidds_shaper #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_shaper (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .launch_i         (shp_launch),
    .prod_i           (mac_acc),
    .pid_i            (pid_q),
    .cfg_i            (cfg_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_speed_o     (left_speed_o),
    .right_speed_o    (right_speed_o),
    .servo_position_o (servo_position_o)
  );

  a_idle_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> mac_idle)
    else $error("multiplier busy while waiting for a request");

  a_prev_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (previous_error_q == $past(position_error_i)))
    else $error("previous error not captured on request");

endmodule
